[rtl/mlp_u1_vertex_limiter_top_defines.svh]
// Assertion macros for the checker file of the vertex limiter.
`ifndef MLP_U1_VERTEX_LIMITER_TOP_DEFINES_SVH
`define MLP_U1_VERTEX_LIMITER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MLV_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MLV_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/mlv_pkg.sv]
`default_nettype none
package mlv_pkg;

   // Fixed-point format of all values.
   localparam int DATA_W    = 32;
   localparam int FRAC_BITS = 16;
   localparam int WIDE_W    = DATA_W + 1;
   // Quotient bits produced by the divider; larger quotients are flagged.
   localparam int QUO_BITS  = DATA_W;
   localparam int TOP_W     = WIDE_W - QUO_BITS + FRAC_BITS;
   localparam int CNT_W     = $clog2(QUO_BITS);

   localparam logic signed [DATA_W-1:0] LIM_ONE = DATA_W'(1) << FRAC_BITS;
   localparam logic signed [DATA_W-1:0] LIM_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic mag;
      logic check;
      logic step;
      logic factor;
      logic update;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic skip;
      logic last;
   } sts_type;

endpackage
`default_nettype wire

[rtl/mlv_ctrl.sv]
`default_nettype none
module mlv_ctrl
   import mlv_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output cmd_type      cmd,
   input  wire sts_type sts
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_MAG    = 3'd1;
   localparam logic [2:0] S_CHECK  = 3'd2;
   localparam logic [2:0] S_DIV    = 3'd3;
   localparam logic [2:0] S_FACTOR = 3'd4;
   localparam logic [2:0] S_UPDATE = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             slot_free;
   logic             update_go;

   // The output register can take a new result once its present one is gone.
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign update_go = (state_ff == S_UPDATE) && (!sts.last || slot_free);

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Commands issued from the present state.
   always_comb begin
      cmd        = '0;
      cmd.load   = req_valid && (state_ff == S_IDLE);
      cmd.mag    = (state_ff == S_MAG);
      cmd.check  = (state_ff == S_CHECK);
      cmd.step   = (state_ff == S_DIV) && !sts.skip;
      cmd.factor = (state_ff == S_FACTOR);
      cmd.update = update_go;
      cmd.emit   = update_go && sts.last;
   end

   // Sequencer for one vertex.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_MAG;
            end
         end
         S_MAG: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            state_in = S_DIV;
            cnt_in   = CNT_W'(QUO_BITS - 1);
         end
         S_DIV: begin
            if (sts.skip || cnt_ff == '0) begin
               state_in = S_FACTOR;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_FACTOR: begin
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            if (update_go) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result valid flag: set on an emitted result, cleared by its transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

[rtl/mlv_datapath.sv]
`default_nettype none
module mlv_datapath
   import mlv_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic signed [DATA_W-1:0] req_p0_value,
   input  wire logic signed [DATA_W-1:0] req_p1_projected,
   input  wire logic signed [DATA_W-1:0] req_allowable_min,
   input  wire logic signed [DATA_W-1:0] req_allowable_max,
   input  wire logic                     req_last_vertex,
   input  wire cmd_type                  cmd,
   output sts_type                       sts,
   output logic signed [DATA_W-1:0]      rsp_cell_factor
);

   logic signed [WIDE_W-1:0] dev_ff, num_ff;
   logic                     last_ff, devz_ff;
   logic [WIDE_W-1:0]        dmag_ff, nmag_ff;
   logic                     neg_ff, ovf_ff;
   logic [WIDE_W-1:0]        rem_ff;
   logic [QUO_BITS-1:0]      qr_ff;
   logic signed [DATA_W-1:0] fac_ff, fac_in;
   logic signed [DATA_W-1:0] run_ff, run_in;
   logic signed [DATA_W-1:0] rsp_ff;

   logic signed [WIDE_W-1:0] p0_w, p1_w, lo_w, hi_w;
   logic [TOP_W-1:0]         top;
   logic [WIDE_W:0]          trial;
   logic signed [DATA_W-1:0] new_min;

   assign sts.skip = devz_ff || ovf_ff;
   assign sts.last = last_ff;
   assign rsp_cell_factor = rsp_ff;

   // Exact 33-bit differences; the bound is chosen by the sign of the deviation.
   assign p0_w = {req_p0_value[DATA_W-1], req_p0_value};
   assign p1_w = {req_p1_projected[DATA_W-1], req_p1_projected};
   assign lo_w = {req_allowable_min[DATA_W-1], req_allowable_min};
   assign hi_w = {req_allowable_max[DATA_W-1], req_allowable_max};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dev_ff  <= p1_w - p0_w;
         num_ff  <= (req_p1_projected < req_p0_value) ? (lo_w - p0_w) : (hi_w - p0_w);
         devz_ff <= (req_p1_projected == req_p0_value);
         last_ff <= req_last_vertex;
      end
   end

   // Magnitudes and the sign of the quotient.
   always_ff @(posedge clock) begin
      if (cmd.mag) begin
         dmag_ff <= dev_ff[WIDE_W-1] ? WIDE_W'(-dev_ff) : WIDE_W'(dev_ff);
         nmag_ff <= num_ff[WIDE_W-1] ? WIDE_W'(-num_ff) : WIDE_W'(num_ff);
         neg_ff  <= num_ff[WIDE_W-1] ^ dev_ff[WIDE_W-1];
      end
   end

   // The scaled dividend is split: its top part seeds the remainder, and
   // a top part not below the divisor means the quotient needs more bits.
   assign top = nmag_ff[WIDE_W-1 -: TOP_W];

   // One restoring division step: shift in the next dividend bit and subtract.
   assign trial = {rem_ff, qr_ff[QUO_BITS-1]} - {1'b0, dmag_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         ovf_ff <= 1'b0;
      end else if (cmd.load) begin
         ovf_ff <= 1'b0;
      end else if (cmd.check) begin
         ovf_ff <= (WIDE_W'(top) >= dmag_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.check) begin
         rem_ff <= WIDE_W'(top);
         qr_ff  <= {nmag_ff[QUO_BITS-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
      end else if (cmd.step) begin
         if (!trial[WIDE_W]) begin
            rem_ff <= trial[WIDE_W-1:0];
            qr_ff  <= {qr_ff[QUO_BITS-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[WIDE_W-2:0], qr_ff[QUO_BITS-1]};
            qr_ff  <= {qr_ff[QUO_BITS-2:0], 1'b0};
         end
      end
   end

   // Vertex factor: sign applied, capped at 1.0, saturated below.
   always_comb begin
      if (devz_ff) begin
         fac_in = LIM_ONE;
      end else if (neg_ff && (ovf_ff || qr_ff != '0)) begin
         if (ovf_ff || qr_ff[QUO_BITS-1]) begin
            fac_in = LIM_MIN;
         end else begin
            fac_in = -$signed(qr_ff);
         end
      end else if (ovf_ff || qr_ff >= QUO_BITS'(LIM_ONE)) begin
         fac_in = LIM_ONE;
      end else begin
         fac_in = $signed(qr_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.factor) begin
         fac_ff <= fac_in;
      end
   end

   // Running minimum over the vertices of the cell.
   assign new_min = (fac_ff < run_ff) ? fac_ff : run_ff;

   always_comb begin
      run_in = run_ff;
      if (cmd.emit) begin
         run_in = LIM_ONE;
      end else if (cmd.update) begin
         run_in = new_min;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= LIM_ONE;
      end else begin
         run_ff <= run_in;
      end
   end

   // Output register for the cell result.
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff <= new_min;
      end
   end

endmodule
`default_nettype wire

[rtl/mlp_u1_vertex_limiter_top.sv]
// MLP-u1 vertex limiter. One transfer on the req_ channel carries one vertex
// of a cell (average, projected value, allowable bounds, all signed Q16.16,
// and a last-vertex flag). The block forms the vertex factor, the bound
// deviation divided by the projected deviation, capped at 1.0 and saturated
// below, and keeps a running minimum that is sent on the rsp_ channel at the
// last vertex of each cell and then returns to 1.0. Vertices are taken one at
// a time: a vertex passes through the magnitude, check, division, factor and
// update states before the next req_ transfer, and the radix-2 restoring
// divider produces one quotient bit per cycle for all 32 quotient bits; a vertex
// with zero deviation or an overflowing quotient does no division steps. A last
// vertex waits in its final cycle while an earlier result is still held in the output register.
`default_nettype none
module mlp_u1_vertex_limiter_top
   import mlv_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic signed [DATA_W-1:0] req_p0_value,
   input  wire logic signed [DATA_W-1:0] req_p1_projected,
   input  wire logic signed [DATA_W-1:0] req_allowable_min,
   input  wire logic signed [DATA_W-1:0] req_allowable_max,
   input  wire logic                     req_last_vertex,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [DATA_W-1:0]      rsp_cell_factor
);

   cmd_type cmd;
   sts_type sts;

   // Sequencer.
   mlv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Arithmetic and running minimum.
   mlv_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_p0_value      (req_p0_value),
      .req_p1_projected  (req_p1_projected),
      .req_allowable_min (req_allowable_min),
      .req_allowable_max (req_allowable_max),
      .req_last_vertex   (req_last_vertex),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_cell_factor   (rsp_cell_factor)
   );

endmodule
`default_nettype wire

[rtl/mlv_checker.sv]
`default_nettype none
`include "mlp_u1_vertex_limiter_top_defines.svh"
module mlv_checker
   import mlv_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_ready,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire logic signed [DATA_W-1:0] rsp_cell_factor
);

   // A stalled result keeps its value.
   `MLV_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(rsp_cell_factor), "result changed while stalled")

   // A cell factor never exceeds 1.0.
   `MLV_ASSERT_SAME(a_rsp_cap, clock, reset, rsp_valid, rsp_cell_factor <= LIM_ONE,
                    "result above 1.0")

   // Vertices are worked on one at a time.
   `MLV_ASSERT_NEXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready,
                    "second vertex taken while busy")

   // A new result only appears after a vertex has been worked on.
   `MLV_ASSERT_SAME(a_rsp_source, clock, reset, $rose(rsp_valid), $past(!req_ready),
                    "result appeared without work")

endmodule

bind mlp_u1_vertex_limiter_top mlv_checker u_mlv_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_cell_factor (rsp_cell_factor)
);
`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 100ps
module tb
   import mlv_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_VERTICES = 1700;
   localparam int TAIL_CYCLES = 80;
   localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

   // One cell vertex as carried by a req_ transfer.
   typedef struct {
      logic signed [DATA_W-1:0] avg;
      logic signed [DATA_W-1:0] proj;
      logic signed [DATA_W-1:0] lo;
      logic signed [DATA_W-1:0] hi;
      logic                     last;
   } vertex_type;

   // Tracks the running cell minimum and holds the cell factors still owed.
   class cell_factor_board_type;
      logic signed [DATA_W-1:0] cell_min;
      logic signed [DATA_W-1:0] owed_factors[$];
      int errors;
      int vertices;
      int cells;
      int checked;
      int zero_dev;
      int at_one;
      int saturated;
      int negative;

      function new();
         cell_min = LIM_ONE;
      endfunction

      // Bound deviation over projected deviation, capped at 1.0, saturated below.
      function automatic logic signed [DATA_W-1:0] vertex_factor(vertex_type v);
         longint dev;
         longint num;
         longint unsigned num_mag;
         longint unsigned dev_mag;
         longint unsigned quo;
         bit neg;
         dev = longint'(v.proj) - longint'(v.avg);
         if (dev == 0) begin
            return LIM_ONE;
         end
         num = (dev < 0) ? longint'(v.lo) - longint'(v.avg) : longint'(v.hi) - longint'(v.avg);
         num_mag = (num < 0) ? -num : num;
         dev_mag = (dev < 0) ? -dev : dev;
         quo = (num_mag << FRAC_BITS) / dev_mag;
         neg = (num < 0) != (dev < 0);
         if (neg && quo != 0) begin
            if (quo >= 64'h8000_0000) begin
               return LIM_MIN;
            end
            return DATA_W'(-longint'(quo));
         end
         if (quo >= (64'd1 << FRAC_BITS)) begin
            return LIM_ONE;
         end
         return DATA_W'(quo);
      endfunction

      // Called for every accepted vertex; a last vertex closes the cell.
      function void note_vertex(vertex_type v);
         logic signed [DATA_W-1:0] f;
         f = vertex_factor(v);
         vertices++;
         if (v.proj == v.avg) zero_dev++;
         if (f == LIM_ONE) at_one++;
         if (f == LIM_MIN) saturated++;
         if (f < 0) negative++;
         if (f < cell_min) cell_min = f;
         if (v.last) begin
            owed_factors.push_back(cell_min);
            cell_min = LIM_ONE;
            cells++;
         end
      endfunction

      task report_mismatch(string msg);
         errors++;
         $display("MISMATCH at %0t ns: %s", $time, msg);
      endtask

      // Called for every accepted rsp_ transfer.
      task check_factor(logic signed [DATA_W-1:0] got);
         logic signed [DATA_W-1:0] want;
         if (owed_factors.size() == 0) begin
            report_mismatch($sformatf("cell factor %h arrived with no cell closed", got));
         end else begin
            want = owed_factors.pop_front();
            checked++;
            if (got !== want) begin
               report_mismatch($sformatf("cell factor got %h (%0d), want %h (%0d)",
                                         got, got, want, want));
            end
         end
      endtask

      function int pending();
         return owed_factors.size();
      endfunction
   endclass

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic signed [DATA_W-1:0] req_p0_value = '0;
   logic signed [DATA_W-1:0] req_p1_projected = '0;
   logic signed [DATA_W-1:0] req_allowable_min = '0;
   logic signed [DATA_W-1:0] req_allowable_max = '0;
   logic                     req_last_vertex = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [DATA_W-1:0] rsp_cell_factor;

   cell_factor_board_type factors = new();
   int idle_cycles = 0;
   int burst_left = 0;

   mlp_u1_vertex_limiter_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_p0_value      (req_p0_value),
      .req_p1_projected  (req_p1_projected),
      .req_allowable_min (req_allowable_min),
      .req_allowable_max (req_allowable_max),
      .req_last_vertex   (req_last_vertex),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_cell_factor   (rsp_cell_factor)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Result checking and the count of cycles without any transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            factors.check_factor(rsp_cell_factor);
         end
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin : watchdog
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("Watchdog: no transfer for %0d cycles, %0d cell factors outstanding",
               WATCHDOG_LIMIT, factors.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // The receiver follows a rotating 64-bit ready pattern, reloaded with a fresh random choice.
   initial begin : rsp_stalls
      bit [63:0] pattern;
      forever begin
         case ($urandom_range(0, 3))
            0: pattern = '1;
            1: pattern = {$urandom, $urandom};
            2: pattern = {$urandom, $urandom} & {$urandom, $urandom};
            default: pattern = '0;
         endcase
         pattern[0] = 1'b1;
         repeat (512) begin
            @(posedge clock);
            rsp_ready <= pattern[0];
            pattern = {pattern[0], pattern[63:1]};
         end
      end
   end

   function automatic vertex_type mk(longint avg, longint proj, longint lo, longint hi,
                                     bit last);
      vertex_type v;
      v.avg = DATA_W'(avg);
      v.proj = DATA_W'(proj);
      v.lo = DATA_W'(lo);
      v.hi = DATA_W'(hi);
      v.last = last;
      return v;
   endfunction

   function automatic logic signed [DATA_W-1:0] edge_value();
      case ($urandom_range(0, 5))
         0: return LIM_MIN;
         1: return VAL_MAX;
         2: return '0;
         3: return '1;
         4: return DATA_W'(1);
         default: return $urandom;
      endcase
   endfunction

   // Mostly plausible vertices (bounds around the average), plus tiny, raw and edge values.
   function automatic vertex_type random_vertex();
      vertex_type v;
      longint base;
      longint swing;
      int kind;
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
         base = longint'($signed($urandom)) >>> $urandom_range(4, 12);
         swing = longint'($urandom_range(0, 3 << 20));
         v = mk(base, ($urandom_range(0, 19) == 0) ? base :
                      ($urandom_range(0, 1) ? base + swing : base - swing),
                base - longint'($urandom_range(0, 1 << 20)),
                base + longint'($urandom_range(0, 1 << 20)), 1'b0);
         // Now and then the bounds land on the wrong side of the average.
         if ($urandom_range(0, 9) == 0) begin
            v.lo = v.hi + DATA_W'($urandom_range(0, 1 << 16));
         end
      end else if (kind < 75) begin
         v = mk(longint'($urandom_range(0, 16)) - 8, longint'($urandom_range(0, 16)) - 8,
                longint'($urandom_range(0, 16)) - 8, longint'($urandom_range(0, 16)) - 8, 1'b0);
      end else if (kind < 90) begin
         v.avg = $urandom;
         v.proj = $urandom;
         v.lo = $urandom;
         v.hi = $urandom;
      end else begin
         v.avg = edge_value();
         v.proj = edge_value();
         v.lo = edge_value();
         v.hi = edge_value();
      end
      v.last = 1'b0;
      return v;
   endfunction

   // Sends one vertex; the sender works in bursts with random gaps between them.
   task automatic send_vertex(input vertex_type v);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 50);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_p0_value <= v.avg;
      req_p1_projected <= v.proj;
      req_allowable_min <= v.lo;
      req_allowable_max <= v.hi;
      req_last_vertex <= v.last;
      do @(posedge clock); while (!req_ready);
      factors.note_vertex(v);
   endtask

   initial begin : stimulus
      vertex_type directed[$];
      vertex_type v;
      int random_sent;
      int cell_len;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed cells covering the special cases of the vertex factor.
      directed.push_back(mk(0, 0, 0, 0, 1));                         // zero deviation
      directed.push_back(mk(-1, -1, LIM_MIN, VAL_MAX, 1));           // zero deviation, all ones
      directed.push_back(mk(VAL_MAX, LIM_MIN, LIM_MIN, VAL_MAX, 1)); // widest negative deviation
      directed.push_back(mk(LIM_MIN, VAL_MAX, LIM_MIN, VAL_MAX, 0)); // widest positive deviation
      directed.push_back(mk(0, 1, 0, LIM_MIN, 1));                   // saturates low
      directed.push_back(mk(0, 1, 0, -32768, 1));                    // quotient just out of range
      directed.push_back(mk(0, 2, 0, -65535, 1));                    // largest negative in range
      directed.push_back(mk(0, 3, 0, -1, 1));                        // truncation toward zero
      directed.push_back(mk(0, -65536, 32768, 0, 1));                // negative deviation, lo above
      directed.push_back(mk(100, 50, 100, 200, 1));                  // zero numerator
      directed.push_back(mk(0, 65536, 0, 262144, 1));                // above 1.0, capped
      directed.push_back(mk(0, -65536, -131072, 0, 1));              // negative side capped
      directed.push_back(mk(0, 65536, 0, 65536, 1));                 // exactly 1.0
      // A cell of several vertices with its minimum in the middle.
      directed.push_back(mk(0, 196608, 0, 65536, 0));
      directed.push_back(mk(0, -196608, -16384, 0, 0));
      directed.push_back(mk(0, 65536, 0, 32768, 0));
      directed.push_back(mk(VAL_MAX, VAL_MAX, 0, 0, 1));
      directed.push_back(mk(LIM_MIN, LIM_MIN + 1, LIM_MIN, LIM_MIN, 1));
      foreach (directed[i]) begin
         send_vertex(directed[i]);
      end

      // Random cells of mostly short length.
      random_sent = 0;
      while (random_sent < RANDOM_VERTICES) begin
         cell_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 5);
         for (int k = 0; k < cell_len; k++) begin
            v = random_vertex();
            v.last = (k == cell_len - 1);
            send_vertex(v);
            random_sent++;
         end
      end
      req_valid <= 1'b0;

      // Drain, then keep watching for any unexpected extra result.
      while (factors.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d vertices in %0d cells and checked %0d cell factors.",
               factors.vertices, factors.cells, factors.checked);
      $display("Vertex factors: %0d zero deviation, %0d at 1.0, %0d negative, %0d saturated.",
               factors.zero_dev, factors.at_one, factors.negative, factors.saturated);
      if (factors.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/mlv_pkg.sv
rtl/mlv_ctrl.sv
rtl/mlv_datapath.sv
rtl/mlp_u1_vertex_limiter_top.sv
rtl/mlv_checker.sv
tb/sv/tb.sv
